// ----- hdl/kss_pkg.sv -----
// Shared constants, types and handshake structs for the k-smallest select unit.
// No dependencies; used by the controller, datapath and top level.
`timescale 1ns / 1ps

package kss_pkg;

  // Depth of the kept list and derived widths
  localparam int MAX_KEEP = 16;
  localparam int CNT_W    = $clog2(MAX_KEEP + 1);
  localparam int IDX_W    = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

  // Fixed field widths
  localparam int DATA_W = 32;
  localparam int KEEP_W = 5;
  localparam int RANK_W = 4;

  localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(5);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic insert;
    logic shift_out;
    logic clear;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last_entry;
  } status_t;

endpackage

// ----- hdl/k_smallest_select_unit.sv -----
// k_smallest_select_unit: keeps the k smallest distances of a set, sorted.
// Throughput: one candidate per cycle while idle; the cell row compares and shifts at once.
// A flagged candidate is inserted in its cycle, then the list drains at one entry
// per output transfer; no input is taken meanwhile.
// The first result is presented in the cycle after the flagged candidate is accepted.
// Reset (rst, synchronous): list empty, keep_count 5, controller idle.
`timescale 1ns / 1ps

module k_smallest_select_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [kss_pkg::KEEP_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [kss_pkg::DATA_W-1:0] distance,
  input  logic [kss_pkg::DATA_W-1:0]        point_id,
  input  logic                              last_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [kss_pkg::DATA_W-1:0] out_distance,
  output logic [kss_pkg::DATA_W-1:0]        out_id,
  output logic [kss_pkg::RANK_W-1:0]        rank,
  output logic                              last_result
);

  logic [kss_pkg::KEEP_W-1:0] keep_count;
  kss_pkg::cmd_t              cmd;
  kss_pkg::status_t           status;

  // Configuration register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count <= kss_pkg::KEEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      keep_count <= cfg_data;
    end
  end

  kss_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_item (last_item),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  kss_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .keep_count   (keep_count),
    .distance     (distance),
    .point_id     (point_id),
    .status       (status),
    .out_distance (out_distance),
    .out_id       (out_id),
    .rank         (rank)
  );

  assign last_result = status.last_entry;

  // Flagged candidate starts emission in the next cycle
  a_emit_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last_item |=> out_valid)
    else $error("emission did not start after final candidate");

  // Final result transfer ends emission
  a_emit_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last_result |=> !out_valid && !in_stall)
    else $error("emission did not end after final result");

  // Inputs held off while results are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input accepted during emission");

  // Rank advances by one per non-final transfer
  a_rank_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_result |=>
      out_valid && (rank == $past(rank) + kss_pkg::RANK_W'(1)))
    else $error("rank did not advance");

endmodule

// ----- hdl/kss_datapath.sv -----
// Datapath: row of compare-and-shift cells holding the sorted kept list,
// fill count and emission rank counter. Depends on kss_pkg.
`timescale 1ns / 1ps

module kss_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  kss_pkg::cmd_t                         cmd,
  input  logic [kss_pkg::KEEP_W-1:0]            keep_count,
  input  logic signed [kss_pkg::DATA_W-1:0]     distance,
  input  logic [kss_pkg::DATA_W-1:0]            point_id,
  output kss_pkg::status_t                      status,
  output logic signed [kss_pkg::DATA_W-1:0]     out_distance,
  output logic [kss_pkg::DATA_W-1:0]            out_id,
  output logic [kss_pkg::RANK_W-1:0]            rank
);

  localparam int N = kss_pkg::MAX_KEEP;
  localparam int CW = kss_pkg::CNT_W;

  logic signed [kss_pkg::DATA_W-1:0] cell_dist [N];
  logic [kss_pkg::DATA_W-1:0]        cell_id   [N];
  logic [CW-1:0]                     fill;
  logic [CW-1:0]                     fill_next;
  logic [kss_pkg::IDX_W-1:0]         rank_cnt;

  logic [CW-1:0] k_eff;
  logic [CW-1:0] fill_cl;
  logic [N-1:0]  valid_mask;
  logic [N-1:0]  le;
  logic          full;
  logic          drop;

  // Clamp keep count into 1..MAX_KEEP
  always_comb begin
    if (keep_count == '0) begin
      k_eff = CW'(1);
    end else if (int'(keep_count) > N) begin
      k_eff = CW'(N);
    end else begin
      k_eff = CW'(keep_count);
    end
  end

  // Cut the list to the current k
  assign fill_cl = (fill > k_eff) ? k_eff : fill;
  assign full    = (fill_cl == k_eff);

  // Each cell compares its entry against the candidate; earlier wins ties
  always_comb begin
    for (int i = 0; i < N; i++) begin
      valid_mask[i] = (CW'(i) < fill_cl);
      le[i]         = valid_mask[i] && (cell_dist[i] <= distance);
    end
  end

  // Candidate falls off the end when the list is full and it ranks last
  assign drop = full && (&(le | ~valid_mask));

  always_comb begin
    fill_next = fill_cl;
    if (!drop && !full) begin
      fill_next = fill_cl + CW'(1);
    end
  end

  // Cell row: insert with shift right, or shift left on emission
  always_ff @(posedge clk) begin
    if (cmd.insert && !drop) begin
      if (!le[0]) begin
        cell_dist[0] <= distance;
        cell_id[0]   <= point_id;
      end
      for (int i = 1; i < N; i++) begin
        if (!le[i]) begin
          if (le[i-1]) begin
            cell_dist[i] <= distance;
            cell_id[i]   <= point_id;
          end else begin
            cell_dist[i] <= cell_dist[i-1];
            cell_id[i]   <= cell_id[i-1];
          end
        end
      end
    end else if (cmd.shift_out) begin
      for (int i = 0; i < N - 1; i++) begin
        cell_dist[i] <= cell_dist[i+1];
        cell_id[i]   <= cell_id[i+1];
      end
    end
  end

  // Fill count and rank counter
  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      rank_cnt <= '0;
    end else if (cmd.clear) begin
      fill     <= '0;
      rank_cnt <= '0;
    end else begin
      if (cmd.insert) begin
        fill <= fill_next;
      end
      if (cmd.shift_out) begin
        rank_cnt <= rank_cnt + kss_pkg::IDX_W'(1);
      end
    end
  end

  assign status.last_entry = ((CW'(rank_cnt) + CW'(1)) == fill);

  assign out_distance = cell_dist[0];
  assign out_id       = cell_id[0];
  assign rank         = kss_pkg::RANK_W'(rank_cnt);

endmodule

// ----- hdl/kss_controller.sv -----
// Controller: accepts candidates while idle and sequences emission of the list
// after the final candidate of a set. Depends on kss_pkg.
`timescale 1ns / 1ps

module kss_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             last_item,
  input  logic             out_stall,
  input  kss_pkg::status_t status,
  output kss_pkg::cmd_t    cmd,
  output logic             in_stall,
  output logic             out_valid
);

  kss_pkg::state_t state;
  kss_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kss_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      kss_pkg::ST_IDLE: begin
        if (in_valid && last_item) begin
          state_next = kss_pkg::ST_EMIT;
        end
      end
      kss_pkg::ST_EMIT: begin
        if (!out_stall && status.last_entry) begin
          state_next = kss_pkg::ST_IDLE;
        end
      end
      default: state_next = kss_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state)
      kss_pkg::ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.insert = in_valid;
      end
      kss_pkg::ST_EMIT: begin
        out_valid     = 1'b1;
        cmd.shift_out = !out_stall;
        cmd.clear     = !out_stall && status.last_entry;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

// ----- tb/kss_pick_checker.sv -----
// Checker for the k-smallest select unit: follows the config, input and output transfers,
// predicts the emitted entries of each set and compares them field by field.
// Depends on kss_pkg for widths and the keep_count reset value.
`timescale 1ns / 1ps

module kss_pick_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [kss_pkg::KEEP_W-1:0]        cfg_data,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic signed [kss_pkg::DATA_W-1:0] distance,
  input  logic [kss_pkg::DATA_W-1:0]        point_id,
  input  logic                              last_item,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [kss_pkg::DATA_W-1:0] out_distance,
  input  logic [kss_pkg::DATA_W-1:0]        out_id,
  input  logic [kss_pkg::RANK_W-1:0]        rank,
  input  logic                              last_result,
  output int                                fail_count,
  output int                                outstanding
);

  typedef struct {
    logic signed [kss_pkg::DATA_W-1:0] dval;
    logic [kss_pkg::DATA_W-1:0]        pid;
    logic [kss_pkg::RANK_W-1:0]        rnk;
    logic                              fin;
  } pick_t;

  // Mirror of the kept list and the keep_count register
  logic signed [kss_pkg::DATA_W-1:0] kept_dist [kss_pkg::MAX_KEEP];
  logic [kss_pkg::DATA_W-1:0]        kept_pid  [kss_pkg::MAX_KEEP];
  int                                kept_fill;
  logic [kss_pkg::KEEP_W-1:0]        keep_reg;
  pick_t                             expected_picks [$];

  // Zero acts as one, anything above the list depth acts as the depth
  function automatic int clamp_keep(input logic [kss_pkg::KEEP_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > kss_pkg::MAX_KEEP) return kss_pkg::MAX_KEEP;
    return int'(v);
  endfunction

  task automatic clear_list();
    int i;
    for (i = 0; i < kss_pkg::MAX_KEEP; i++) begin
      kept_dist[i] = '0;
      kept_pid[i]  = '0;
    end
    kept_fill = 0;
  endtask

  // Append one predicted entry behind the older ones
  task automatic queue_pick(input pick_t p);
    expected_picks.insert(expected_picks.size(), p);
  endtask

  // Insert one candidate in order (ties behind earlier entries); emit the list on a flagged one
  task automatic absorb_candidate(input logic signed [kss_pkg::DATA_W-1:0] d,
                                  input logic [kss_pkg::DATA_W-1:0] pid, input logic flag);
    int    k;
    int    pos;
    int    stop;
    int    i;
    pick_t p;
    k = clamp_keep(keep_reg);
    if (kept_fill > k) kept_fill = k;
    pos = 0;
    while (pos < kept_fill && kept_dist[pos] <= d) pos++;
    if (pos < k) begin
      stop = (kept_fill < k) ? kept_fill : k - 1;
      for (i = stop; i > pos; i--) begin
        kept_dist[i] = kept_dist[i-1];
        kept_pid[i]  = kept_pid[i-1];
      end
      kept_dist[pos] = d;
      kept_pid[pos]  = pid;
      if (kept_fill < k) kept_fill++;
    end
    if (flag) begin
      for (i = 0; i < kept_fill; i++) begin
        p.dval = kept_dist[i];
        p.pid  = kept_pid[i];
        p.rnk  = kss_pkg::RANK_W'(i);
        p.fin  = (i + 1 == kept_fill);
        queue_pick(p);
      end
      clear_list();
    end
  endtask

  // Compare one output transfer with the oldest expected entry
  task automatic check_pick();
    pick_t p;
    if (expected_picks.size() == 0) begin
      $display("%0t: unexpected result dist=%0d id=%h rank=%0d last=%b", $time,
               out_distance, out_id, rank, last_result);
      fail_count++;
      return;
    end
    p = expected_picks.pop_front();
    if (out_distance !== p.dval) begin
      $display("%0t: out_distance expected %0d actual %0d", $time, p.dval, out_distance);
      fail_count++;
    end
    if (out_id !== p.pid) begin
      $display("%0t: out_id expected %h actual %h", $time, p.pid, out_id);
      fail_count++;
    end
    if (rank !== p.rnk) begin
      $display("%0t: rank expected %0d actual %0d", $time, p.rnk, rank);
      fail_count++;
    end
    if (last_result !== p.fin) begin
      $display("%0t: last_result expected %b actual %b", $time, p.fin, last_result);
      fail_count++;
    end
  endtask

  // Sample every channel at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      keep_reg = kss_pkg::KEEP_RESET;
      clear_list();
      expected_picks.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid === 1'b1 && cfg_ready === 1'b1) keep_reg = cfg_data;
      if (in_valid === 1'b1 && in_stall === 1'b0) absorb_candidate(distance, point_id, last_item);
      if (out_valid === 1'b1 && out_stall === 1'b0) check_pick();
    end
    outstanding = expected_picks.size();
  end

endmodule

// ----- tb/tb.sv -----
// Top of the k-smallest select unit testbench: clock, reset, candidate and config stimulus,
// random output stalls and the verdict. Depends on kss_pkg, the unit and kss_pick_checker.
`timescale 1ns / 1ps

module tb;

  localparam int RANDOM_ITEMS = 230;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE       = 4;
  localparam logic signed [kss_pkg::DATA_W-1:0] DIST_MIN = 32'sh8000_0000;
  localparam logic signed [kss_pkg::DATA_W-1:0] DIST_MAX = 32'sh7FFF_FFFF;

  logic                              clk;
  logic                              rst;
  logic                              cfg_valid;
  logic                              cfg_ready;
  logic [kss_pkg::KEEP_W-1:0]        cfg_data;
  logic                              in_valid;
  logic                              in_stall;
  logic signed [kss_pkg::DATA_W-1:0] distance;
  logic [kss_pkg::DATA_W-1:0]        point_id;
  logic                              last_item;
  logic                              out_valid;
  logic                              out_stall;
  logic signed [kss_pkg::DATA_W-1:0] out_distance;
  logic [kss_pkg::DATA_W-1:0]        out_id;
  logic [kss_pkg::RANK_W-1:0]        rank;
  logic                              last_result;
  int                                fail_count;
  int                                outstanding;
  int                                idle_pct;
  int                                sent_count;
  int                                cycles;

  k_smallest_select_unit uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .distance(distance), .point_id(point_id), .last_item(last_item),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_distance(out_distance), .out_id(out_id), .rank(rank), .last_result(last_result)
  );

  kss_pick_checker chk (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .distance(distance), .point_id(point_id), .last_item(last_item),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_distance(out_distance), .out_id(out_id), .rank(rank), .last_result(last_result),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Random receiver stall, changed at the falling edge
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  // Give up after a generous number of cycles
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  // Offer one candidate, idling first at random; hold it until the transfer
  task automatic push_candidate(input logic signed [kss_pkg::DATA_W-1:0] d,
                                input logic [kss_pkg::DATA_W-1:0] pid, input logic flag);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    distance  <= d;
    point_id  <= pid;
    last_item <= flag;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
    @(negedge clk);
  endtask

  // Hold the sender until every expected entry has arrived, then let the list settle
  task automatic settle();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_keep(input logic [kss_pkg::KEEP_W-1:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mix of extremes, narrow values that force ties, and full-range values
  function automatic logic signed [kss_pkg::DATA_W-1:0] pick_distance();
    case ($urandom_range(9))
      0: return DIST_MIN;
      1: return DIST_MAX;
      2, 3, 4: return $signed(kss_pkg::DATA_W'($urandom_range(15))) - 8;
      default: return $signed($urandom());
    endcase
  endfunction

  function automatic logic [kss_pkg::KEEP_W-1:0] pick_keep();
    case ($urandom_range(7))
      0: return '0;
      1: return kss_pkg::KEEP_W'($urandom_range(31, 17));
      2: return kss_pkg::KEEP_W'(kss_pkg::MAX_KEEP);
      3: return kss_pkg::KEEP_W'(1);
      default: return kss_pkg::KEEP_W'($urandom_range(kss_pkg::MAX_KEEP, 1));
    endcase
  endfunction

  // One random set, optionally with a keep_count change half way through
  task automatic run_set(input int len, input bit mid_change);
    int n;
    for (n = 0; n < len; n++) begin
      if (mid_change && n == len / 2) write_keep(pick_keep());
      push_candidate(pick_distance(), $urandom(), n == len - 1);
    end
  endtask

  initial begin
    int set_no;
    int len;
    int random_start;
    rst        = 1'b1;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    distance   = '0;
    point_id   = '0;
    last_item  = 1'b0;
    idle_pct   = 17;
    sent_count = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Lone flagged candidate under the reset keep_count
    push_candidate(DIST_MIN, 32'hFFFF_FFFF, 1'b1);
    // Extremes and ties, more candidates than kept
    push_candidate(DIST_MAX, 32'd1, 1'b0);
    push_candidate(32'sd0, 32'd2, 1'b0);
    push_candidate(-32'sd1, 32'd3, 1'b0);
    push_candidate(32'sd0, 32'd4, 1'b0);
    push_candidate(DIST_MIN, 32'd5, 1'b0);
    push_candidate(DIST_MAX, 32'd6, 1'b1);
    // keep_count zero acts as one
    write_keep('0);
    push_candidate(32'sd10, 32'd7, 1'b0);
    push_candidate(32'sd10, 32'd8, 1'b0);
    push_candidate(32'sd3, 32'd9, 1'b1);
    // keep_count above the depth acts as the depth
    write_keep(5'd31);
    push_candidate(-32'sd5, 32'hA5A5_A5A5, 1'b0);
    push_candidate(-32'sd5, 32'h5A5A_5A5A, 1'b1);
    // Lower keep_count within a set: drop the largest entries
    write_keep(5'd4);
    push_candidate(32'sd40, 32'd11, 1'b0);
    push_candidate(32'sd30, 32'd12, 1'b0);
    push_candidate(32'sd20, 32'd13, 1'b0);
    push_candidate(32'sd10, 32'd14, 1'b0);
    write_keep(5'd2);
    push_candidate(32'sd25, 32'd15, 1'b1);
    // Raise keep_count within a set: dropped entries stay dropped
    write_keep(5'd1);
    push_candidate(32'sd7, 32'd16, 1'b0);
    push_candidate(32'sd5, 32'd17, 1'b0);
    write_keep(5'd3);
    push_candidate(32'sd9, 32'd18, 1'b0);
    push_candidate(32'sd6, 32'd19, 1'b1);

    // Random sets, with a stretch of sets run without any idling
    random_start = sent_count;
    set_no = 0;
    while (sent_count - random_start < RANDOM_ITEMS) begin
      idle_pct = (set_no >= 6 && set_no < 12) ? 0 : 17;
      len = ($urandom_range(7) == 0) ? $urandom_range(40, 1) : $urandom_range(20, 1);
      write_keep(pick_keep());
      run_set(len, len >= 2 && $urandom_range(5) == 0);
      set_no++;
    end

    // Drain and give the verdict
    settle();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
